[hdl/ifmt_pkg.sv]
package ifmt_pkg;

    // Operand and field limits
    localparam int VALUE_BITS = 64;
    localparam int MAX_FIELD  = 40;

    // Digit buffer: octal needs the most digits of any base
    localparam int NDIG     = (VALUE_BITS + 2) / 3;
    localparam int DIG_BITS = 4 * NDIG;
    localparam int OCT_BITS = 3 * NDIG;
    localparam int NDIG_W   = $clog2(NDIG + 1);
    localparam int CNT_W    = $clog2(MAX_FIELD + NDIG + 4);
    localparam int STEP_W   = $clog2(VALUE_BITS);

    // Stream payload layout
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 8;

    localparam int POS_VALUE  = 0;
    localparam int POS_ALT    = 64;
    localparam int POS_ZPAD   = 65;
    localparam int POS_LEFT   = 66;
    localparam int POS_SPACE  = 67;
    localparam int POS_PLUS   = 68;
    localparam int POS_UPPER  = 69;
    localparam int POS_WIDTH  = 70;
    localparam int POS_PREC   = 76;
    localparam int POS_SIZE   = 0;
    localparam int POS_MODE   = 2;

    // ASCII codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_X_LO    = 8'h78;
    localparam logic [7:0] CH_UP_BASE = 8'h41 - 8'd10;
    localparam logic [7:0] CH_LO_BASE = 8'h61 - 8'd10;

    typedef enum logic [1:0] {
        MODE_SDEC = 2'd0,
        MODE_UDEC = 2'd1,
        MODE_OCT  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic conv_step;
        logic norm_step;
        logic size;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_dec;
        logic norm_done;
        logic out_free;
        logic emit_done;
    } status_t;

endpackage

[hdl/ifmt_ctrl.sv]
module ifmt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ifmt_pkg::status_t status,
    output ifmt_pkg::cmd_t   cmd
);
    import ifmt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CONV,
        ST_NORM,
        ST_SIZE,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && s_valid;
        cmd.load      = (state_reg == ST_LOAD);
        cmd.conv_step = (state_reg == ST_CONV);
        cmd.norm_step = (state_reg == ST_NORM) && !status.norm_done;
        cmd.size      = (state_reg == ST_SIZE);
        cmd.emit      = (state_reg == ST_EMIT) && !status.emit_done && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= status.is_dec ? ST_CONV : ST_NORM;
                end
                ST_CONV: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(VALUE_BITS - 1)) begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (status.norm_done) begin
                        state_reg <= ST_SIZE;
                    end
                end
                ST_SIZE: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (status.emit_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/ifmt_datapath.sv]
module ifmt_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ifmt_pkg::IN_DATA_W-1:0]   s_data,
    input  logic [ifmt_pkg::IN_USER_W-1:0]   s_user,
    input  ifmt_pkg::cmd_t                   cmd,
    output ifmt_pkg::status_t                status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ifmt_pkg::OUT_DATA_W-1:0]  m_data,
    output logic                             m_last
);
    import ifmt_pkg::*;

    // Captured item
    logic [VALUE_BITS-1:0] raw_reg;
    logic [1:0]            size_reg;
    mode_t                 mode_reg;
    logic                  alt_reg, zpad_reg, left_reg, spc_reg, plus_reg, upper_reg;
    logic [5:0]            width_reg;
    logic [6:0]            prec_reg;

    // Conversion
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [DIG_BITS-1:0]   dig_reg;
    logic [NDIG_W-1:0]     ndig_reg;

    // Emission counters
    logic [CNT_W-1:0] sp_lead_reg, sp_trail_reg, zero_reg, remain_reg;
    logic [1:0]       pre_reg;
    logic [7:0]       pre0_reg, pre1_reg;

    // Output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_last_reg;

    // Magnitude
    logic [7:0]            size_bits;
    logic [VALUE_BITS-1:0] mask, ext, mag;
    logic                  sign_bit, neg;
    logic [OCT_BITS-1:0]   oct_pad;
    logic [DIG_BITS-1:0]   oct_load, hex_load, load_dig;
    logic [DIG_BITS-1:0]   adj;
    logic [3:0]            top;
    logic                  top_zero, out_free;

    // Sizing
    logic             given;
    logic [CNT_W-1:0] width_c, prec_c, ndig_c, nzero_c, npre_c, content_c, nspace_c, total_c;
    logic [1:0]       npre_s;
    logic [7:0]       pch0, pch1, dig_char;

    always_comb begin
        size_bits = 8'd8 << size_reg;
        for (int b = 0; b < VALUE_BITS; b++) begin
            mask[b] = (b < int'(size_bits));
        end
        sign_bit = |(raw_reg & mask & ~(mask >> 1));
        neg      = (mode_reg == MODE_SDEC) && sign_bit;
        ext      = (raw_reg & mask) | (neg ? ~mask : '0);
        mag      = neg ? (~ext + VALUE_BITS'(1)) : ext;

        oct_pad  = OCT_BITS'(mag);
        hex_load = DIG_BITS'(mag);
        for (int i = 0; i < NDIG; i++) begin
            oct_load[4*i +: 4] = {1'b0, oct_pad[3*i +: 3]};
        end
        case (mode_reg)
            MODE_OCT: load_dig = oct_load;
            MODE_HEX: load_dig = hex_load;
            default:  load_dig = '0;
        endcase

        // Add three to every BCD digit of five or more before the shift
        for (int i = 0; i < NDIG; i++) begin
            adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                         : dig_reg[4*i +: 4];
        end
    end

    assign top      = dig_reg[DIG_BITS-1 -: 4];
    assign top_zero = (top == 4'd0);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (top < 4'd10) begin
            dig_char = CH_ZERO + {4'd0, top};
        end else begin
            dig_char = (upper_reg ? CH_UP_BASE : CH_LO_BASE) + {4'd0, top};
        end
    end

    // Field layout from digit count, flags, width and precision
    always_comb begin
        given   = !prec_reg[6];
        width_c = (width_reg > MAX_FIELD) ? CNT_W'(MAX_FIELD) : CNT_W'(width_reg);
        if (!given) begin
            prec_c = CNT_W'(1);
        end else if (prec_reg[5:0] > MAX_FIELD) begin
            prec_c = CNT_W'(MAX_FIELD);
        end else begin
            prec_c = CNT_W'(prec_reg[5:0]);
        end
        ndig_c = CNT_W'(ndig_reg);
        if (mode_reg == MODE_OCT && alt_reg && prec_c <= ndig_c) begin
            prec_c = ndig_c + 1'b1;
        end

        pch0   = CH_SPACE;
        pch1   = CH_SPACE;
        npre_s = 2'd0;
        if (neg_reg) begin
            pch0   = CH_MINUS;
            npre_s = 2'd1;
        end else if (mode_reg == MODE_SDEC && plus_reg) begin
            pch0   = CH_PLUS;
            npre_s = 2'd1;
        end else if (mode_reg == MODE_SDEC && spc_reg) begin
            pch0   = CH_SPACE;
            npre_s = 2'd1;
        end else if (mode_reg == MODE_HEX && alt_reg && ndig_reg != '0) begin
            pch0   = CH_ZERO;
            pch1   = upper_reg ? CH_X_UP : CH_X_LO;
            npre_s = 2'd2;
        end
        npre_c = CNT_W'(npre_s);

        nzero_c   = (prec_c > ndig_c) ? prec_c - ndig_c : '0;
        content_c = npre_c + nzero_c + ndig_c;
        if (zpad_reg && !left_reg && !given && width_c > content_c) begin
            nzero_c   = nzero_c + (width_c - content_c);
            content_c = width_c;
        end
        nspace_c = (width_c > content_c) ? width_c - content_c : '0;
        total_c  = content_c + nspace_c;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            raw_reg   <= s_data[POS_VALUE +: VALUE_BITS];
            alt_reg   <= s_data[POS_ALT];
            zpad_reg  <= s_data[POS_ZPAD];
            left_reg  <= s_data[POS_LEFT];
            spc_reg   <= s_data[POS_SPACE];
            plus_reg  <= s_data[POS_PLUS];
            upper_reg <= s_data[POS_UPPER];
            width_reg <= s_data[POS_WIDTH +: 6];
            prec_reg  <= s_data[POS_PREC +: 7];
            size_reg  <= s_user[POS_SIZE +: 2];
            mode_reg  <= mode_t'(s_user[POS_MODE +: 2]);
        end

        if (cmd.load) begin
            neg_reg  <= neg;
            mag_reg  <= mag;
            dig_reg  <= load_dig;
            ndig_reg <= NDIG_W'(NDIG);
        end else if (cmd.conv_step) begin
            dig_reg <= {adj[DIG_BITS-2:0], mag_reg[VALUE_BITS-1]};
            mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
        end else if (cmd.norm_step) begin
            dig_reg  <= {dig_reg[DIG_BITS-5:0], 4'd0};
            ndig_reg <= ndig_reg - 1'b1;
        end

        if (cmd.size) begin
            sp_lead_reg  <= left_reg ? '0 : nspace_c;
            sp_trail_reg <= left_reg ? nspace_c : '0;
            zero_reg     <= nzero_c;
            pre_reg      <= npre_s;
            pre0_reg     <= pch0;
            pre1_reg     <= pch1;
        end

        if (cmd.emit) begin
            m_last_reg <= (remain_reg == CNT_W'(1));
            if (sp_lead_reg != '0) begin
                m_data_reg  <= CH_SPACE;
                sp_lead_reg <= sp_lead_reg - 1'b1;
            end else if (pre_reg != 2'd0) begin
                m_data_reg <= pre0_reg;
                pre0_reg   <= pre1_reg;
                pre_reg    <= pre_reg - 1'b1;
            end else if (zero_reg != '0) begin
                m_data_reg <= CH_ZERO;
                zero_reg   <= zero_reg - 1'b1;
            end else if (ndig_reg != '0) begin
                m_data_reg <= dig_char;
                dig_reg    <= {dig_reg[DIG_BITS-5:0], 4'd0};
                ndig_reg   <= ndig_reg - 1'b1;
            end else begin
                m_data_reg   <= CH_SPACE;
                sp_trail_reg <= sp_trail_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            remain_reg  <= '0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.size) begin
                remain_reg <= total_c;
            end else if (cmd.emit) begin
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    assign status.is_dec    = (mode_reg == MODE_SDEC) || (mode_reg == MODE_UDEC);
    assign status.norm_done = !top_zero || (ndig_reg == '0);
    assign status.out_free  = out_free;
    assign status.emit_done = (remain_reg == '0);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free && remain_reg != '0)
        else $error("character emitted with no room or nothing left");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && remain_reg == CNT_W'(1) |=> m_valid && m_last && remain_reg == '0)
        else $error("final character not marked last");

    a_norm_zero_top: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.norm_step |-> top_zero && ndig_reg != '0)
        else $error("normalization dropped a significant digit");

    a_mid_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && remain_reg > CNT_W'(1) |=> !m_last)
        else $error("character marked last too early");

endmodule

[hdl/integer_field_formatter_top.sv]
// Throughput: one item at a time; the 64-step shift-add-3 binary to BCD loop and the
//   one-digit-per-cycle normalization scan run first, then one character per cycle while
//   the output register is free (m_axis_tready low stalls it).
// Reset: aresetn is synchronous, active low; it empties the output register and idles.
module integer_field_formatter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [63:0] value, [64] alt_form, [65] zero_pad, [66] left_justify, [67] space_sign,
    // [68] plus_sign, [69] upper_case, [75:70] field_width, [82:76] precision, [87:83] zero
    input  logic [87:0] s_axis_tdata,
    // [1:0] value_size, [3:2] mode
    input  logic [3:0]  s_axis_tuser,
    // Result items, one per character
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_char
    output logic [7:0]  m_axis_tdata,
    // last_char: final character of the field
    output logic        m_axis_tlast
);
    import ifmt_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence capture, conversion, normalization, sizing and emission
    ifmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the item, build the digit buffer, count out the field and drive the output
    // register, which lets a new item in while the final character still waits
    ifmt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifmt_pkg::*;

    // Flag bits for building directed items: {upper, plus, space, left, zero, alt}
    localparam logic [5:0] FL_NONE  = 6'h00;
    localparam logic [5:0] FL_ALT   = 6'h01;
    localparam logic [5:0] FL_ZPAD  = 6'h02;
    localparam logic [5:0] FL_LEFT  = 6'h04;
    localparam logic [5:0] FL_SPACE = 6'h08;
    localparam logic [5:0] FL_PLUS  = 6'h10;
    localparam logic [5:0] FL_UPPER = 6'h20;

    // Operand sizes as carried in tuser
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    // Precision with the sign bit set means no precision given
    localparam logic [6:0] PREC_NONE = 7'h40;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int STALL_LIMIT    = 3000;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  size;
        mode_t       mode;
        logic        alt;
        logic        zpad;
        logic        left;
        logic        spc;
        logic        plus;
        logic        upper;
        logic [5:0]  width;
        logic [6:0]  prec;
    } fmt_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fmt_char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // [63:0] value, [64] alt, [65] zpad, [66] left, [67] space,
                                 // [68] plus, [69] upper, [75:70] width, [82:76] prec
    logic [3:0]  s_axis_tuser;   // [1:0] value_size, [3:2] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_char
    logic        m_axis_tlast;   // last_char

    // Characters still owed by the block, oldest first
    fmt_char_t expected_chars[$];

    int  mismatches;
    int  fields_sent;
    int  empty_fields;
    int  chars_checked;
    int  idle_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  rx_hold_req;

    integer_field_formatter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Work out the characters of one conversion and queue them as expected results.
    // Layout: leading spaces, sign or prefix, zeros, digits, trailing spaces.
    function automatic void predict_field(fmt_req_t r);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [7:0]  pre[2];
        logic [7:0]  digs[24];
        logic [7:0]  field[$];
        logic [3:0]  d;
        int          bits;
        int          npre;
        int          ndig;
        int          nzero;
        int          content;
        int          nspace;
        int          wid;
        int          prec;
        int          i;
        bit          prec_given;

        bits = 8 << r.size;
        if (bits > VALUE_BITS)
            bits = VALUE_BITS;
        mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
        mag  = r.value & mask;
        npre = 0;
        ndig = 0;

        wid = int'(r.width);
        if (wid > MAX_FIELD)
            wid = MAX_FIELD;
        prec_given = !r.prec[6];
        prec = prec_given ? int'(r.prec) : 1;
        if (prec > MAX_FIELD)
            prec = MAX_FIELD;

        // Sign only matters for signed decimal; sign-extend from the operand size
        if (r.mode == MODE_SDEC) begin
            if (mag[bits-1]) begin
                mag = 64'd0 - (mag | ~mask);
                pre[npre] = CH_MINUS;
                npre = npre + 1;
            end else if (r.plus) begin
                pre[npre] = CH_PLUS;
                npre = npre + 1;
            end else if (r.spc) begin
                pre[npre] = CH_SPACE;
                npre = npre + 1;
            end
        end

        // Digits come out least significant first
        case (r.mode)
            MODE_SDEC, MODE_UDEC: begin
                while (mag != 64'd0) begin
                    digs[ndig] = CH_ZERO + 8'(mag % 64'd10);
                    mag = mag / 64'd10;
                    ndig = ndig + 1;
                end
            end
            MODE_OCT: begin
                while (mag != 64'd0) begin
                    digs[ndig] = CH_ZERO + 8'(mag[2:0]);
                    mag = mag >> 3;
                    ndig = ndig + 1;
                end
                // Alternate octal: force a leading zero digit
                if (r.alt && prec <= ndig)
                    prec = ndig + 1;
            end
            default: begin
                while (mag != 64'd0) begin
                    d = mag[3:0];
                    if (d < 4'd10)
                        digs[ndig] = CH_ZERO + 8'(d);
                    else
                        digs[ndig] = (r.upper ? CH_UP_BASE : CH_LO_BASE) + 8'(d);
                    mag = mag >> 4;
                    ndig = ndig + 1;
                end
                // No 0x on a zero value
                if (r.alt && ndig != 0) begin
                    pre[0] = CH_ZERO;
                    pre[1] = r.upper ? CH_X_UP : CH_X_LO;
                    npre = 2;
                end
            end
        endcase

        nzero   = (prec > ndig) ? prec - ndig : 0;
        content = npre + nzero + ndig;
        if (r.zpad && !r.left && !prec_given && wid > content) begin
            nzero   = nzero + wid - content;
            content = wid;
        end
        nspace = (wid > content) ? wid - content : 0;

        if (!r.left)
            for (i = 0; i < nspace; i++) field.push_back(CH_SPACE);
        for (i = 0; i < npre; i++) field.push_back(pre[i]);
        for (i = 0; i < nzero; i++) field.push_back(CH_ZERO);
        for (i = ndig - 1; i >= 0; i--) field.push_back(digs[i]);
        if (r.left)
            for (i = 0; i < nspace; i++) field.push_back(CH_SPACE);

        if (field.size() == 0)
            empty_fields++;
        for (i = 0; i < field.size(); i++)
            expected_chars.push_back('{ch: field[i], last: (i == field.size() - 1)});
    endfunction

    function automatic fmt_req_t make_req(logic [63:0] value, logic [1:0] size, mode_t mode,
                                          logic [5:0] flags, logic [5:0] width,
                                          logic [6:0] prec);
        fmt_req_t r;
        r.value = value;
        r.size  = size;
        r.mode  = mode;
        r.alt   = flags[0];
        r.zpad  = flags[1];
        r.left  = flags[2];
        r.spc   = flags[3];
        r.plus  = flags[4];
        r.upper = flags[5];
        r.width = width;
        r.prec  = prec;
        return r;
    endfunction

    // Random item biased toward the corners that matter: zero, small values,
    // the sign boundary of each size and all ones, with junk above the operand
    function automatic fmt_req_t rand_req();
        fmt_req_t    r;
        logic [63:0] v;
        logic [63:0] edge_bit;
        int          bits;

        r = make_req(64'd0, 2'($urandom_range(0, 3)), mode_t'(2'($urandom_range(0, 3))),
                     6'($urandom), 6'($urandom_range(0, 63)), 7'd0);
        bits = 8 << r.size;
        edge_bit = 64'd1 << (bits - 1);
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: r.value = v;
            1: r.value = {v[63:8], 8'd0} | 64'($urandom_range(0, 20));
            2: r.value = 64'd0;
            3: r.value = v ^ ((v ^ (edge_bit + 64'($urandom_range(0, 3)) - 64'd2)) &
                              ((bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1)));
            4: r.value = '1;
            default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        // About a third with no precision, the rest over the whole positive range
        if ($urandom_range(0, 2) == 0)
            r.prec = PREC_NONE | 7'($urandom_range(0, 63));
        else
            r.prec = 7'($urandom_range(0, 63));
        // Keep most widths inside the field limit
        if ($urandom_range(0, 3) != 0)
            r.width = 6'($urandom_range(0, 24));
        return r;
    endfunction

    // Offer one item after an optional gap and hold it until the block takes it
    task automatic send_req(fmt_req_t r);
        int gap;

        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, r.prec, r.width, r.upper, r.plus, r.spc, r.left, r.zpad,
                          r.alt, r.value};
        s_axis_tuser  <= {r.mode, r.size};
        do @(posedge aclk); while (!s_axis_tready);
        predict_field(r);
        fields_sent++;
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("ERROR @%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compare every accepted character with the oldest one owed
    always @(posedge aclk) begin
        fmt_char_t want;

        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character", m_axis_tdata, 8'h00);
            end else begin
                want = expected_chars.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch("out_char", m_axis_tdata, want.ch);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_char", 8'(m_axis_tlast), 8'(want.last));
            end
        end
    end

    // Receiver: random stalls per character, plus a long hold-off on request
    initial begin
        int stall;

        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Watchdog: end the run if neither side moves an item for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    // Extremes of every field, every mode and each corner of the formatting rules
    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_req(make_req(64'd0, SZ_8, MODE_SDEC, FL_NONE, 6'd0, PREC_NONE));
        // zero with precision zero: nothing at all
        send_req(make_req(64'd0, SZ_32, MODE_UDEC, FL_NONE, 6'd0, 7'd0));
        send_req(make_req(64'd0, SZ_32, MODE_SDEC, FL_PLUS, 6'd0, 7'd0));
        send_req(make_req(64'h80, SZ_8, MODE_SDEC, FL_NONE, 6'd0, PREC_NONE));
        send_req(make_req('1, SZ_64, MODE_SDEC, FL_NONE, 6'd0, PREC_NONE));
        send_req(make_req(64'h8000_0000_0000_0000, SZ_64, MODE_SDEC, FL_NONE, 6'd0, PREC_NONE));
        send_req(make_req('1, SZ_64, MODE_UDEC, FL_NONE, 6'd0, PREC_NONE));
        send_req(make_req('1, SZ_64, MODE_OCT, FL_ALT, 6'd0, PREC_NONE));
        // octal alternate form of zero still prints a zero
        send_req(make_req(64'd0, SZ_16, MODE_OCT, FL_ALT, 6'd0, 7'd0));
        // hex alternate form of zero: no prefix
        send_req(make_req(64'd0, SZ_16, MODE_HEX, FL_ALT, 6'd5, PREC_NONE));
        send_req(make_req(64'h1234_5678_DEAD_BEEF, SZ_32, MODE_HEX, FL_ALT | FL_UPPER, 6'd0,
                          PREC_NONE));
        send_req(make_req(64'hDEAD_BEEF, SZ_32, MODE_HEX, FL_ALT | FL_ZPAD, 6'd20, PREC_NONE));
        // left wins over zero fill
        send_req(make_req(64'hFFFF_FF85, SZ_32, MODE_SDEC, FL_LEFT | FL_ZPAD, 6'd12,
                          PREC_NONE));
        // plus wins over space
        send_req(make_req(64'd42, SZ_16, MODE_SDEC, FL_PLUS | FL_SPACE, 6'd6, PREC_NONE));
        send_req(make_req(64'd42, SZ_16, MODE_SDEC, FL_SPACE, 6'd0, 7'd5));
        // sign flags, alternate form and upper case where they do nothing
        send_req(make_req(64'd42, SZ_16, MODE_UDEC, FL_PLUS | FL_SPACE | FL_ALT, 6'd0,
                          PREC_NONE));
        send_req(make_req(64'd42, SZ_8, MODE_SDEC, FL_ALT | FL_UPPER, 6'd0, PREC_NONE));
        send_req(make_req(64'hFEDC, SZ_16, MODE_OCT, FL_UPPER, 6'd0, PREC_NONE));
        // width and precision past the field limit saturate
        send_req(make_req(64'd7, SZ_8, MODE_UDEC, FL_NONE, 6'd63, 7'd63));
        // the all-ones negative precision and zero fill to the full width
        send_req(make_req(64'hFFFF_FFFF_FFFF_FFF0, SZ_64, MODE_SDEC, FL_ZPAD, 6'd40, 7'h7F));
        // a given precision turns zero fill back into spaces
        send_req(make_req(64'd99, SZ_8, MODE_UDEC, FL_ZPAD, 6'd10, 7'd4));
        // operand size truncates, signed sizes sign-extend
        send_req(make_req(64'h1234_8000, SZ_16, MODE_SDEC, FL_NONE, 6'd0, PREC_NONE));
        send_req(make_req(64'hABCD_EF01_7FFF_FFFF, SZ_32, MODE_SDEC, FL_PLUS, 6'd0,
                          PREC_NONE));
        send_req(make_req(64'hFACE_B00C, SZ_64, MODE_HEX, FL_LEFT | FL_ALT, 6'd40, PREC_NONE));
        send_req(make_req('1, SZ_64, MODE_OCT, FL_ALT | FL_LEFT, 6'd63, 7'd40));
    endtask

    // Random items with the idling of both sides switched on and off in stretches
    task automatic test_random_mix();
        for (int n = 0; n < 250; n++) begin
            if (n % 40 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_req(rand_req());
        end
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // block fills up and stalls its input
    task automatic test_output_hold();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b1;
        for (int n = 0; n < 35; n++)
            send_req(rand_req());
    endtask

    // Back-to-back on both sides
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int n = 0; n < 60; n++)
            send_req(rand_req());
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        rx_hold_req   = 1'b0;
        mismatches    = 0;
        fields_sent   = 0;
        empty_fields  = 0;
        chars_checked = 0;
        idle_cycles   = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_mix();
        test_output_hold();
        test_full_rate();

        // Drop valid, drain what is owed, then give the block time to show strays
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d fields (%0d with no characters), %0d characters checked,",
                 fields_sent, empty_fields, chars_checked);
        $display("all sizes, modes and flag mixes, random gaps on both sides, one long output hold");
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches, %0d characters never arrived", mismatches,
                     expected_chars.size());
            $display("tb failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ifmt_pkg.sv
hdl/ifmt_ctrl.sv
hdl/ifmt_datapath.sv
hdl/integer_field_formatter_top.sv
tb/tb.sv
